// ===== hdl/mrs_pkg.sv =====
// package with types and constants for the motor run sequencer
`timescale 1ns / 1ps

package mrs_pkg;

	localparam int unsigned SpeedW     = 32;
	localparam int unsigned TimeW      = 32;
	localparam int unsigned StopSpeedW = 31;
	localparam int unsigned ConfirmW   = 16;
	localparam int unsigned ClassW     = 3;
	localparam int unsigned InDataW    = 72;
	localparam int unsigned OutDataW   = 8;
	localparam int unsigned CfgIndexW  = 1;

	// 10 rpm expressed in rad/s, unsigned Q15.16
	localparam logic [StopSpeedW-1:0] StopSpeedRst = 31'd68629;
	localparam logic [ConfirmW-1:0]   ConfirmRst   = 16'd100;

	localparam logic [CfgIndexW-1:0] RegStopSpeed = 1'd0;
	localparam logic [CfgIndexW-1:0] RegConfirm   = 1'd1;

	localparam logic [ClassW-1:0] ClsStandby = 3'd0;
	localparam logic [ClassW-1:0] ClsReady   = 3'd3;
	localparam logic [ClassW-1:0] ClsFault   = 3'd4;

	typedef enum logic [1:0] {
		ST_STOPPED  = 2'd0,
		ST_STARTING = 2'd1,
		ST_RUNNING  = 2'd2,
		ST_DECEL    = 2'd3
	} run_state_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_ENABLE  = 3'd1,
		ACT_DISABLE = 3'd2,
		ACT_CALIB   = 3'd3,
		ACT_ZERO    = 3'd4
	} action_t;

endpackage

// ===== hdl/motor_run_sequencer.sv =====
// run/stop sequencer for a field-oriented motor drive
`timescale 1ns / 1ps

// Usage:
//  Input stream s_*: s_tuser is the item kind (1 = toggle the run request,
//  0 = task step); a task step carries the controller status class, the
//  signed Q16.16 speed and the millisecond tick in s_tdata.
//  Output stream m_*: one result per input item, in order, with the run
//  state, the action code and the gate, init and run request flags.
//  Config port: cfg_we writes cfg_wdata to register cfg_index
//  (0 stop speed threshold, 1 confirm time in ms); write only while idle.
//  Path: an input item passes the input register, then the result register,
//  before its result is valid. Throughput: one item per cycle while the
//  receiver accepts results; the state update is a single short decision
//  between the input and result registers.
//  When the receiver stalls, the result register holds and s_tready drops
//  only once both the input and result registers are full.
//  Reset (arst_n low) empties both registers, puts the sequencer in the
//  stopped state with all flags clear and loads the register defaults.
module motor_run_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// status_class[2:0], speed[34:3], now_ms[66:35], zero fill
	input  logic [mrs_pkg::InDataW-1:0]   s_tdata,
	// op[0]
	input  logic [0:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// run_state[1:0], action[4:2], drive_enabled[5], is_initialized[6],
	// run_requested[7]
	output logic [mrs_pkg::OutDataW-1:0]  m_tdata,
	input  logic                          cfg_we,
	input  logic [mrs_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [mrs_pkg::StopSpeedW-1:0] cfg_wdata
);

	logic [mrs_pkg::StopSpeedW-1:0] stop_speed_q;
	logic [mrs_pkg::ConfirmW-1:0]   confirm_q;

	logic                         valid_s1;
	logic                         op_s1;
	logic [mrs_pkg::ClassW-1:0]   cls_s1;
	logic [mrs_pkg::SpeedW-1:0]   speed_s1;
	logic [mrs_pkg::TimeW-1:0]    now_s1;

	mrs_pkg::run_state_t st_q, st_d;
	logic run_q, run_d;
	logic gate_q, gate_d;
	logic init_q, init_d;
	logic below_q, below_d;
	logic [mrs_pkg::TimeW-1:0] since_q, since_d;
	mrs_pkg::action_t act;

	logic                         out_valid_q;
	logic [mrs_pkg::OutDataW-1:0] out_data_q;

	logic                         adv;
	logic                         step;
	logic [mrs_pkg::SpeedW-1:0]   mag;
	logic                         below_thr;
	logic [mrs_pkg::TimeW-1:0]    elapsed;
	logic                         confirmed;
	logic                         active;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign step     = valid_s1 && adv;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// most negative speed keeps magnitude 2^31 and never counts as below
	assign mag       = speed_s1[mrs_pkg::SpeedW-1] ?
		({mrs_pkg::SpeedW{1'b0}} - speed_s1) : speed_s1;
	assign below_thr = mag < {1'b0, stop_speed_q};
	assign elapsed   = now_s1 - since_q;
	assign confirmed = elapsed >= {{(mrs_pkg::TimeW - mrs_pkg::ConfirmW){1'b0}}, confirm_q};
	assign active    = (st_q == mrs_pkg::ST_RUNNING) || (st_q == mrs_pkg::ST_DECEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_speed_q <= mrs_pkg::StopSpeedRst;
			confirm_q    <= mrs_pkg::ConfirmRst;
		end else if (cfg_we) begin
			case (cfg_index)
				mrs_pkg::RegStopSpeed: stop_speed_q <= cfg_wdata;
				mrs_pkg::RegConfirm:   confirm_q <= cfg_wdata[mrs_pkg::ConfirmW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1    <= s_tuser[0];
			cls_s1   <= s_tdata[2:0];
			speed_s1 <= s_tdata[34:3];
			now_s1   <= s_tdata[66:35];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= mrs_pkg::ST_STOPPED;
			run_q   <= 1'b0;
			gate_q  <= 1'b0;
			init_q  <= 1'b0;
			below_q <= 1'b0;
			since_q <= '0;
		end else if (step) begin
			st_q    <= st_d;
			run_q   <= run_d;
			gate_q  <= gate_d;
			init_q  <= init_d;
			below_q <= below_d;
			since_q <= since_d;
		end
	end

	always_comb begin
		st_d    = st_q;
		run_d   = run_q;
		gate_d  = gate_q;
		init_d  = init_q;
		below_d = below_q;
		since_d = since_q;
		act     = mrs_pkg::ACT_NONE;
		if (op_s1) begin
			run_d = !run_q;
		end else if (init_q && active && cls_s1 >= mrs_pkg::ClsFault) begin
			// hard stop on fault
			run_d   = 1'b0;
			gate_d  = 1'b0;
			below_d = 1'b0;
			st_d    = mrs_pkg::ST_STOPPED;
			act     = mrs_pkg::ACT_DISABLE;
		end else begin
			case (st_q)
				mrs_pkg::ST_STOPPED: begin
					if (run_q) st_d = mrs_pkg::ST_STARTING;
				end
				mrs_pkg::ST_STARTING: begin
					if (!run_q || (init_q && cls_s1 != mrs_pkg::ClsReady)) begin
						if (run_q) run_d = 1'b0;
						gate_d  = 1'b0;
						below_d = 1'b0;
						st_d    = mrs_pkg::ST_STOPPED;
						act     = mrs_pkg::ACT_DISABLE;
					end else if (cls_s1 == mrs_pkg::ClsReady) begin
						init_d = 1'b1;
						gate_d = 1'b1;
						st_d   = mrs_pkg::ST_RUNNING;
						act    = mrs_pkg::ACT_ENABLE;
					end else if (cls_s1 == mrs_pkg::ClsStandby) begin
						act = mrs_pkg::ACT_CALIB;
					end
				end
				mrs_pkg::ST_RUNNING: begin
					if (!run_q) begin
						below_d = 1'b0;
						st_d    = mrs_pkg::ST_DECEL;
						act     = mrs_pkg::ACT_ZERO;
					end
				end
				mrs_pkg::ST_DECEL: begin
					if (run_q) begin
						below_d = 1'b0;
						st_d    = mrs_pkg::ST_RUNNING;
					end else begin
						act = mrs_pkg::ACT_ZERO;
						if (!below_thr) begin
							below_d = 1'b0;
						end else if (!below_q) begin
							below_d = 1'b1;
							since_d = now_s1;
						end else if (confirmed) begin
							gate_d  = 1'b0;
							below_d = 1'b0;
							st_d    = mrs_pkg::ST_STOPPED;
							act     = mrs_pkg::ACT_DISABLE;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= {run_d, init_d, gate_d, act, st_d};
		end
	end

	// gate only on while running or ramping down
	a_gate_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[5] |-> (m_tdata[1:0] == mrs_pkg::ST_RUNNING ||
		m_tdata[1:0] == mrs_pkg::ST_DECEL))
		else $error("gate on outside running or decelerating");

	a_enable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4:2] == mrs_pkg::ACT_ENABLE |->
		m_tdata[5] && m_tdata[6] && m_tdata[1:0] == mrs_pkg::ST_RUNNING)
		else $error("enable result without running, gate and init");

	a_disable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4:2] == mrs_pkg::ACT_DISABLE |->
		!m_tdata[5] && m_tdata[1:0] == mrs_pkg::ST_STOPPED)
		else $error("disable result without stop");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(st_q) && $stable(run_q) && $stable(gate_q))
		else $error("sequencer state moved without a step");

endmodule
